// File: src/msrp_pkg.sv
package msrp_pkg;

   localparam logic [1:0] OP_START   = 2'd0;
   localparam logic [1:0] OP_RX_BYTE = 2'd1;
   localparam logic [1:0] OP_TICK    = 2'd2;

   localparam logic KIND_TX     = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FORMAT  = 2'd1;
   localparam logic [1:0] STATUS_CRC     = 2'd2;
   localparam logic [1:0] STATUS_TIMEOUT = 2'd3;

   localparam int unsigned CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SLAVE_ADDRESS = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT_MS    = 1'd1;

   localparam logic [7:0]  SLAVE_ADDRESS_RESET = 8'd1;
   localparam logic [15:0] TIMEOUT_MS_RESET    = 16'd1000;

   localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
   localparam logic [7:0]  REPLY_BYTE_COUNT  = 8'h02;
   localparam logic [7:0]  REQ_START_HI      = 8'h00;
   localparam logic [7:0]  REQ_START_LO      = 8'h00;
   localparam logic [7:0]  REQ_COUNT_HI      = 8'h00;
   localparam logic [7:0]  REQ_COUNT_LO      = 8'h01;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [3:0]  IDX_ADDRESS     = 4'd0;
   localparam logic [3:0]  IDX_FUNCTION    = 4'd1;
   localparam logic [3:0]  IDX_BYTE_COUNT  = 4'd2;
   localparam logic [3:0]  IDX_DATA_HI     = 4'd3;
   localparam logic [3:0]  IDX_DATA_LO     = 4'd4;
   localparam logic [3:0]  IDX_CRC_LO      = 4'd5;
   localparam logic [3:0]  IDX_CRC_HI      = 4'd6;
   localparam logic [3:0]  INDEX_MAX       = 4'd15;
   localparam logic [16:0] TICK_MAX        = 17'h1FFFF;

   localparam logic [2:0]  TX_IDX_CRC_LO = 3'd6;
   localparam logic [2:0]  TX_IDX_CRC_HI = 3'd7;

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] rx_byte;
      logic       rx_last;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  tx_byte;
      logic        tx_last;
      logic [1:0]  status;
      logic [15:0] reading;
      logic [31:0] error_count;
   } rsp_type;

   typedef struct packed {
      logic        is_status;
      logic [1:0]  status;
      logic [15:0] reading;
      logic [31:0] error_count;
      logic [7:0]  address;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_status_type;

   function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// File: src/msrp_front.sv
module msrp_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  msrp_pkg::req_type                   req_data,
   input  logic                                csr_valid,
   input  logic [msrp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [15:0]                         csr_data,
   input  msrp_pkg::fifo_status_type           fifo_status,
   output logic                                push,
   output msrp_pkg::job_type                   push_job
);

   logic [7:0]  slave_address_ff, slave_address_in;
   logic [15:0] timeout_ms_ff, timeout_ms_in;
   logic        waiting_ff, waiting_in;
   logic [16:0] elapsed_ff, elapsed_in;
   logic [3:0]  byte_index_ff, byte_index_in;
   logic        header_good_ff, header_good_in;
   logic [15:0] running_crc_ff, running_crc_in;
   logic [15:0] data_word_ff, data_word_in;
   logic [15:0] received_crc_ff, received_crc_in;
   logic [31:0] errors_ff, errors_in;

   logic        accept;
   logic [15:0] crc_next;
   logic [16:0] tick_next;
   logic        clear;

   assign req_ready = !fifo_status.full;
   assign accept    = req_valid && req_ready;
   assign crc_next  = msrp_pkg::crc_update(running_crc_ff, req_data.rx_byte);
   assign tick_next = (elapsed_ff == msrp_pkg::TICK_MAX) ? elapsed_ff : elapsed_ff + 17'd1;

   always_comb begin
      slave_address_in = slave_address_ff;
      timeout_ms_in    = timeout_ms_ff;
      waiting_in       = waiting_ff;
      elapsed_in       = elapsed_ff;
      byte_index_in    = byte_index_ff;
      header_good_in   = header_good_ff;
      running_crc_in   = running_crc_ff;
      data_word_in     = data_word_ff;
      received_crc_in  = received_crc_ff;
      errors_in        = errors_ff;
      clear            = 1'b0;
      push             = 1'b0;
      push_job         = '0;

      if (csr_valid) begin
         case (csr_index)
            msrp_pkg::CSR_SLAVE_ADDRESS: slave_address_in = csr_data[7:0];
            msrp_pkg::CSR_TIMEOUT_MS:    timeout_ms_in    = csr_data;
            default: ;
         endcase
      end

      if (accept) begin
         case (req_data.operation)
            msrp_pkg::OP_START: begin
               push                 = 1'b1;
               push_job.is_status   = 1'b0;
               push_job.address     = slave_address_ff;
               push_job.error_count = errors_ff;
               waiting_in           = 1'b1;
               elapsed_in           = '0;
               clear                = 1'b1;
            end
            msrp_pkg::OP_RX_BYTE: begin
               if (waiting_ff) begin
                  case (byte_index_ff)
                     msrp_pkg::IDX_ADDRESS:
                        if (req_data.rx_byte != slave_address_ff) header_good_in = 1'b0;
                     msrp_pkg::IDX_FUNCTION:
                        if (req_data.rx_byte != msrp_pkg::FUNC_READ_HOLDING) header_good_in = 1'b0;
                     msrp_pkg::IDX_BYTE_COUNT:
                        if (req_data.rx_byte != msrp_pkg::REPLY_BYTE_COUNT) header_good_in = 1'b0;
                     msrp_pkg::IDX_DATA_HI: data_word_in = {req_data.rx_byte, 8'h00};
                     msrp_pkg::IDX_DATA_LO: data_word_in = {data_word_ff[15:8], req_data.rx_byte};
                     msrp_pkg::IDX_CRC_LO:  received_crc_in = {8'h00, req_data.rx_byte};
                     msrp_pkg::IDX_CRC_HI:
                        received_crc_in = {req_data.rx_byte, received_crc_ff[7:0]};
                     default: ;
                  endcase
                  if (byte_index_ff < msrp_pkg::IDX_CRC_LO) running_crc_in = crc_next;
                  if (byte_index_ff != msrp_pkg::INDEX_MAX) byte_index_in = byte_index_ff + 4'd1;
                  if (req_data.rx_last) begin
                     waiting_in         = 1'b0;
                     clear              = 1'b1;
                     push               = 1'b1;
                     push_job.is_status = 1'b1;
                     if (byte_index_ff != msrp_pkg::IDX_CRC_HI || !header_good_ff) begin
                        push_job.status = msrp_pkg::STATUS_FORMAT;
                     end else if (running_crc_ff != {req_data.rx_byte, received_crc_ff[7:0]}) begin
                        push_job.status = msrp_pkg::STATUS_CRC;
                     end else begin
                        push_job.status  = msrp_pkg::STATUS_OK;
                        push_job.reading = data_word_ff;
                     end
                     if (push_job.status != msrp_pkg::STATUS_OK) errors_in = errors_ff + 32'd1;
                     push_job.error_count = errors_in;
                  end
               end
            end
            msrp_pkg::OP_TICK: begin
               if (waiting_ff) begin
                  elapsed_in = tick_next;
                  if (tick_next > {1'b0, timeout_ms_ff}) begin
                     waiting_in           = 1'b0;
                     clear                = 1'b1;
                     push                 = 1'b1;
                     errors_in            = errors_ff + 32'd1;
                     push_job.is_status   = 1'b1;
                     push_job.status      = msrp_pkg::STATUS_TIMEOUT;
                     push_job.error_count = errors_in;
                  end
               end
            end
            default: ;
         endcase
      end

      if (clear) begin
         byte_index_in   = '0;
         header_good_in  = 1'b1;
         running_crc_in  = msrp_pkg::CRC_INIT;
         data_word_in    = '0;
         received_crc_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slave_address_ff <= msrp_pkg::SLAVE_ADDRESS_RESET;
         timeout_ms_ff    <= msrp_pkg::TIMEOUT_MS_RESET;
         waiting_ff       <= 1'b0;
         elapsed_ff       <= '0;
         byte_index_ff    <= '0;
         header_good_ff   <= 1'b1;
         running_crc_ff   <= msrp_pkg::CRC_INIT;
         data_word_ff     <= '0;
         received_crc_ff  <= '0;
         errors_ff        <= '0;
      end else begin
         slave_address_ff <= slave_address_in;
         timeout_ms_ff    <= timeout_ms_in;
         waiting_ff       <= waiting_in;
         elapsed_ff       <= elapsed_in;
         byte_index_ff    <= byte_index_in;
         header_good_ff   <= header_good_in;
         running_crc_ff   <= running_crc_in;
         data_word_ff     <= data_word_in;
         received_crc_ff  <= received_crc_in;
         errors_ff        <= errors_in;
      end
   end

endmodule

// File: src/msrp_fifo.sv
module msrp_fifo #(
   parameter int unsigned DEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  msrp_pkg::job_type           push_job,
   input  logic                        pop,
   output msrp_pkg::job_type           head,
   output msrp_pkg::fifo_status_type   fifo_status
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   msrp_pkg::job_type  entries_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;

   assign head              = entries_ff[rd_ptr_ff];
   assign fifo_status.full  = (count_ff == CNT_W'(DEPTH));
   assign fifo_status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: src/msrp_back.sv
module msrp_back (
   input  logic                       clock,
   input  logic                       reset,
   input  msrp_pkg::job_type          head,
   input  msrp_pkg::fifo_status_type  fifo_status,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output msrp_pkg::rsp_type          rsp_data
);

   logic              rsp_valid_ff, rsp_valid_in;
   msrp_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic [2:0]        tx_idx_ff, tx_idx_in;
   logic [15:0]       tx_crc_ff, tx_crc_in;

   logic              load;
   logic [7:0]        tx_byte;
   logic [15:0]       crc_base;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign load      = !rsp_valid_ff || rsp_ready;
   assign crc_base  = (tx_idx_ff == '0) ? msrp_pkg::CRC_INIT : tx_crc_ff;

   always_comb begin
      case (tx_idx_ff)
         3'd0:                    tx_byte = head.address;
         3'd1:                    tx_byte = msrp_pkg::FUNC_READ_HOLDING;
         3'd2:                    tx_byte = msrp_pkg::REQ_START_HI;
         3'd3:                    tx_byte = msrp_pkg::REQ_START_LO;
         3'd4:                    tx_byte = msrp_pkg::REQ_COUNT_HI;
         3'd5:                    tx_byte = msrp_pkg::REQ_COUNT_LO;
         msrp_pkg::TX_IDX_CRC_LO: tx_byte = tx_crc_ff[7:0];
         msrp_pkg::TX_IDX_CRC_HI: tx_byte = tx_crc_ff[15:8];
         default:                 tx_byte = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      tx_idx_in    = tx_idx_ff;
      tx_crc_in    = tx_crc_ff;
      pop          = 1'b0;
      if (load) begin
         rsp_valid_in = 1'b0;
         if (!fifo_status.empty) begin
            rsp_valid_in            = 1'b1;
            rsp_data_in             = '0;
            rsp_data_in.error_count = head.error_count;
            if (head.is_status) begin
               rsp_data_in.kind    = msrp_pkg::KIND_STATUS;
               rsp_data_in.status  = head.status;
               rsp_data_in.reading = head.reading;
               pop                 = 1'b1;
            end else begin
               rsp_data_in.kind    = msrp_pkg::KIND_TX;
               rsp_data_in.tx_byte = tx_byte;
               if (tx_idx_ff < msrp_pkg::TX_IDX_CRC_LO) begin
                  tx_crc_in = msrp_pkg::crc_update(crc_base, tx_byte);
               end
               if (tx_idx_ff == msrp_pkg::TX_IDX_CRC_HI) begin
                  rsp_data_in.tx_last = 1'b1;
                  tx_idx_in           = '0;
                  pop                 = 1'b1;
               end else begin
                  tx_idx_in = tx_idx_ff + 3'd1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         tx_idx_ff    <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         tx_idx_ff    <= tx_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      tx_crc_ff   <= tx_crc_in;
   end

endmodule

// File: src/modbus_single_register_poller.sv
// A result passes the job queue and then the result register before it is offered.
// Throughput: one request transaction per cycle while the job queue has room; the
// result side gives one result per cycle while rsp_ready is high; a start has 8 bytes.
// Reset (synchronous): slave address 1, timeout 1000 ticks, wait disarmed, error
// count zero, job queue and result register empty.
module modbus_single_register_poller #(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  msrp_pkg::req_type                 req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output msrp_pkg::rsp_type                 rsp_data,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [msrp_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [15:0]                       csr_data
);

   msrp_pkg::fifo_status_type fifo_status;
   msrp_pkg::job_type         push_job;
   msrp_pkg::job_type         head;
   logic                      push;
   logic                      pop;

   assign csr_ready = 1'b1;

   msrp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .csr_valid   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .fifo_status (fifo_status),
      .push        (push),
      .push_job    (push_job)
   );

   msrp_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_fifo (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .push_job    (push_job),
      .pop         (pop),
      .head        (head),
      .fifo_status (fifo_status)
   );

   msrp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .fifo_status (fifo_status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   assert property (@(posedge clock) disable iff (reset) push |-> !fifo_status.full)
      else $error("job pushed into a full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> !fifo_status.empty)
      else $error("job popped from an empty queue");

   assert property (@(posedge clock) disable iff (reset)
      (pop && !head.is_status) |=> (rsp_valid && rsp_data.tx_last))
      else $error("start job retired before its last request byte");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.kind == msrp_pkg::KIND_STATUS) |->
      (!rsp_data.tx_last && rsp_data.tx_byte == 8'h00))
      else $error("status result carries transmit fields");

endmodule

// File: bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int LONG_HOLD = 300;
   localparam int STALL_LIMIT = 3000;
   localparam int SETTLE_CYCLES = 16;
   localparam int RANDOM_OPS_PER_SETTING = 50;

   typedef struct {
      msrp_pkg::req_type word;
      bit                settle;
   } bus_op_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   msrp_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   msrp_pkg::rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [msrp_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [15:0] csr_data = '0;

   modbus_single_register_poller DUT (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data,
      .csr_valid,
      .csr_ready,
      .csr_index,
      .csr_data
   );

   always #5 clock = ~clock;

   bus_op_type outgoing_ops[$];
   msrp_pkg::rsp_type awaited_results[$];

   logic [7:0]  cfg_address = msrp_pkg::SLAVE_ADDRESS_RESET;
   logic [15:0] cfg_timeout = msrp_pkg::TIMEOUT_MS_RESET;

   logic        wait_armed = 1'b0;
   logic [16:0] tick_count = '0;
   logic [3:0]  frame_pos = '0;
   logic        header_ok = 1'b1;
   logic [15:0] crc_acc = msrp_pkg::CRC_INIT;
   logic [15:0] reply_word = '0;
   logic [15:0] reply_crc = '0;
   logic [31:0] error_total = '0;

   int status_seen [4] = '{0, 0, 0, 0};
   int tx_bytes_seen = 0;
   int ops_taken = 0;
   int results_taken = 0;
   int csr_writes = 0;
   int mismatches = 0;

   logic req_taken = 1'b0;
   int send_gap = 0;
   int send_calm = 0;
   int take_gap = 0;
   int take_calm = 0;
   int hold_left = 0;
   int holds_asked = 0;
   int holds_done = 0;
   int idle_cycles = 0;

   function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] c;
      c = acc ^ {8'h00, b};
      repeat (8) c = c[0] ? ((c >> 1) ^ msrp_pkg::CRC_POLY) : (c >> 1);
      return c;
   endfunction

   function automatic int idle_len();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 65) return 0;
      if (pick < 95) return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   task automatic post_tx_byte(input logic [7:0] b, input logic last);
      msrp_pkg::rsp_type r;
      r = '0;
      r.kind = msrp_pkg::KIND_TX;
      r.tx_byte = b;
      r.tx_last = last;
      r.status = msrp_pkg::STATUS_OK;
      r.error_count = error_total;
      awaited_results.push_back(r);
      tx_bytes_seen++;
   endtask

   task automatic post_status(input logic [1:0] st, input logic [15:0] value);
      msrp_pkg::rsp_type r;
      if (st != msrp_pkg::STATUS_OK) error_total++;
      r = '0;
      r.kind = msrp_pkg::KIND_STATUS;
      r.status = st;
      r.reading = value;
      r.error_count = error_total;
      awaited_results.push_back(r);
      status_seen[st]++;
   endtask

   task automatic drop_partial_reply();
      frame_pos = '0;
      header_ok = 1'b1;
      crc_acc = msrp_pkg::CRC_INIT;
      reply_word = '0;
      reply_crc = '0;
   endtask

   task automatic poll_master_step(input msrp_pkg::req_type item);
      logic [7:0]  frame [6];
      logic [15:0] crc;
      logic [3:0]  pos;
      case (item.operation)
         msrp_pkg::OP_START: begin
            frame = '{cfg_address, msrp_pkg::FUNC_READ_HOLDING, msrp_pkg::REQ_START_HI,
                      msrp_pkg::REQ_START_LO, msrp_pkg::REQ_COUNT_HI,
                      msrp_pkg::REQ_COUNT_LO};
            crc = msrp_pkg::CRC_INIT;
            foreach (frame[k]) begin
               crc = crc16_step(crc, frame[k]);
               post_tx_byte(frame[k], 1'b0);
            end
            post_tx_byte(crc[7:0], 1'b0);
            post_tx_byte(crc[15:8], 1'b1);
            drop_partial_reply();
            tick_count = '0;
            wait_armed = 1'b1;
         end
         msrp_pkg::OP_RX_BYTE: if (wait_armed) begin
            pos = frame_pos;
            case (pos)
               msrp_pkg::IDX_ADDRESS:
                  if (item.rx_byte != cfg_address) header_ok = 1'b0;
               msrp_pkg::IDX_FUNCTION:
                  if (item.rx_byte != msrp_pkg::FUNC_READ_HOLDING) header_ok = 1'b0;
               msrp_pkg::IDX_BYTE_COUNT:
                  if (item.rx_byte != msrp_pkg::REPLY_BYTE_COUNT) header_ok = 1'b0;
               msrp_pkg::IDX_DATA_HI: reply_word = {item.rx_byte, 8'h00};
               msrp_pkg::IDX_DATA_LO: reply_word[7:0] = item.rx_byte;
               msrp_pkg::IDX_CRC_LO: reply_crc = {8'h00, item.rx_byte};
               msrp_pkg::IDX_CRC_HI: reply_crc[15:8] = item.rx_byte;
               default: ;
            endcase
            if (pos < msrp_pkg::IDX_CRC_LO) crc_acc = crc16_step(crc_acc, item.rx_byte);
            if (frame_pos != msrp_pkg::INDEX_MAX) frame_pos++;
            if (item.rx_last) begin
               wait_armed = 1'b0;
               if (pos != msrp_pkg::IDX_CRC_HI || !header_ok)
                  post_status(msrp_pkg::STATUS_FORMAT, '0);
               else if (crc_acc != reply_crc) post_status(msrp_pkg::STATUS_CRC, '0);
               else post_status(msrp_pkg::STATUS_OK, reply_word);
               drop_partial_reply();
            end
         end
         msrp_pkg::OP_TICK: if (wait_armed) begin
            if (tick_count != msrp_pkg::TICK_MAX) tick_count++;
            if (tick_count > {1'b0, cfg_timeout}) begin
               wait_armed = 1'b0;
               drop_partial_reply();
               post_status(msrp_pkg::STATUS_TIMEOUT, '0);
            end
         end
         default: ;
      endcase
   endtask

   // sample handshakes, predict and check
   always @(posedge clock) begin : monitor
      msrp_pkg::rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && req_ready;
         if (req_valid && req_ready) begin
            poll_master_step(req_data);
            ops_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            results_taken++;
            if (awaited_results.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result: kind %0d tx_byte %02h status %0d reading %04h",
                           rsp_data.kind, rsp_data.tx_byte, rsp_data.status, rsp_data.reading);
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.kind !== want.kind || rsp_data.tx_byte !== want.tx_byte
                   || rsp_data.tx_last !== want.tx_last || rsp_data.status !== want.status
                   || rsp_data.reading !== want.reading
                   || rsp_data.error_count !== want.error_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch (expected/actual): kind %0d/%0d tx_byte %02h/%02h ",
                               "tx_last %0d/%0d status %0d/%0d reading %04h/%04h ",
                               "errors %0d/%0d"},
                              want.kind, rsp_data.kind, want.tx_byte, rsp_data.tx_byte,
                              want.tx_last, rsp_data.tx_last, want.status, rsp_data.status,
                              want.reading, rsp_data.reading,
                              want.error_count, rsp_data.error_count);
               end
            end
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles == STALL_LIMIT) begin
            $display("no transaction for %0d cycles, %0d results still awaited",
                     STALL_LIMIT, awaited_results.size());
            $display("[modbus_single_register_poller] ERROR");
            $finish;
         end
      end
   end

   always @(negedge clock) begin : sender
      bus_op_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_taken) begin
         if (send_gap != 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (outgoing_ops.size() != 0
                      && !(outgoing_ops[0].settle && awaited_results.size() != 0)) begin
            nxt = outgoing_ops.pop_front();
            req_data <= nxt.word;
            req_valid <= 1'b1;
            if (send_calm != 0) send_calm--;
            else if ($urandom_range(0, 99) == 0) send_calm = $urandom_range(40, 150);
            else send_gap = idle_len();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (holds_done != holds_asked) begin
         holds_done++;
         hold_left = LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (take_gap != 0) begin
         take_gap--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (take_calm != 0) take_calm--;
         else if ($urandom_range(0, 99) == 0) take_calm = $urandom_range(40, 150);
         else take_gap = idle_len();
      end
   end

   task automatic queue_op(input logic [1:0] op, input logic [7:0] b, input logic l,
                           input bit settle);
      bus_op_type e;
      e.word.operation = op;
      e.word.rx_byte = b;
      e.word.rx_last = l;
      e.settle = settle;
      outgoing_ops.push_back(e);
   endtask

   task automatic make_reply(input logic [7:0] adr, input logic [15:0] word,
                             output logic [7:0] f[$]);
      logic [15:0] crc;
      f = {adr, msrp_pkg::FUNC_READ_HOLDING, msrp_pkg::REPLY_BYTE_COUNT,
           word[15:8], word[7:0]};
      crc = msrp_pkg::CRC_INIT;
      foreach (f[k]) crc = crc16_step(crc, f[k]);
      f.push_back(crc[7:0]);
      f.push_back(crc[15:8]);
   endtask

   task automatic queue_reply(input logic [7:0] f[$], input bit mark_last, input int tick_odds);
      foreach (f[i]) begin
         if (tick_odds != 0 && $urandom_range(1, tick_odds) == 1)
            queue_op(msrp_pkg::OP_TICK, 8'($urandom), 1'($urandom), 1'b0);
         queue_op(msrp_pkg::OP_RX_BYTE, f[i], mark_last && (i == f.size() - 1), 1'b0);
      end
   endtask

   task automatic add_random_sequence();
      logic [7:0]  fr[$];
      logic [15:0] word;
      int pick;
      int flaw;
      int n;
      bit settle;
      settle = ($urandom_range(0, 11) == 0);
      pick = $urandom_range(0, 99);
      case ($urandom_range(0, 7))
         0: word = 16'h0000;
         1: word = 16'hFFFF;
         default: word = 16'($urandom);
      endcase
      make_reply(cfg_address, word, fr);
      if (pick < 70) begin
         queue_op(msrp_pkg::OP_START, 8'($urandom), 1'($urandom), settle);
         flaw = $urandom_range(0, 9);
         case (flaw)
            0: fr[0] ^= 8'($urandom_range(1, 255));
            1: fr[1] ^= 8'($urandom_range(1, 255));
            2: fr[2] ^= 8'($urandom_range(1, 255));
            3: fr[$urandom_range(3, 6)] ^= 8'($urandom_range(1, 255));
            4: begin
               n = $urandom_range(1, 6);
               while (fr.size() > n) void'(fr.pop_back());
            end
            5: repeat ($urandom_range(1, 11)) fr.push_back(8'($urandom));
            default: ;
         endcase
         queue_reply(fr, flaw != 6, 10);
      end else if (pick < 80) begin
         queue_op(msrp_pkg::OP_START, 8'($urandom), 1'($urandom), settle);
         n = $urandom_range(1, 5);
         while (fr.size() > n) void'(fr.pop_back());
         queue_reply(fr, 1'b0, 0);
      end else if (pick < 90) begin
         repeat ($urandom_range(1, 8))
            queue_op(msrp_pkg::OP_TICK, 8'($urandom), 1'($urandom), settle);
      end else begin
         repeat ($urandom_range(1, 4))
            queue_op(2'($urandom_range(0, 3)), 8'($urandom), 1'($urandom), settle);
      end
   endtask

   task automatic settle_all();
      while (outgoing_ops.size() != 0 || req_valid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [msrp_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [15:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data = value;
      do @(posedge clock); while (!csr_ready);
      if (idx == msrp_pkg::CSR_SLAVE_ADDRESS) cfg_address = value[7:0];
      else cfg_timeout = value;
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   initial begin
      logic [7:0] fr[$];
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: idle traffic, restart, good, crc and short replies
      @(posedge clock);
      queue_op(msrp_pkg::OP_RX_BYTE, 8'hA5, 1'b1, 1'b0);
      queue_op(msrp_pkg::OP_TICK, 8'h5A, 1'b0, 1'b0);
      queue_op(OP_UNUSED, 8'hFF, 1'b1, 1'b0);
      queue_op(msrp_pkg::OP_START, 8'h00, 1'b0, 1'b0);
      queue_op(msrp_pkg::OP_RX_BYTE, msrp_pkg::SLAVE_ADDRESS_RESET, 1'b0, 1'b0);
      queue_op(msrp_pkg::OP_RX_BYTE, msrp_pkg::FUNC_READ_HOLDING, 1'b0, 1'b0);
      queue_op(msrp_pkg::OP_RX_BYTE, msrp_pkg::REPLY_BYTE_COUNT, 1'b0, 1'b0);
      queue_op(msrp_pkg::OP_START, 8'hFF, 1'b1, 1'b0);
      make_reply(msrp_pkg::SLAVE_ADDRESS_RESET, 16'hFFFF, fr);
      queue_reply(fr, 1'b1, 0);
      queue_op(msrp_pkg::OP_START, 8'h00, 1'b0, 1'b0);
      make_reply(msrp_pkg::SLAVE_ADDRESS_RESET, 16'h0000, fr);
      fr[6] ^= 8'h80;
      queue_reply(fr, 1'b1, 0);
      queue_op(msrp_pkg::OP_START, 8'h00, 1'b0, 1'b0);
      queue_op(msrp_pkg::OP_RX_BYTE, 8'h00, 1'b1, 1'b0);
      settle_all();

      // lowest address, zero timeout
      write_reg(msrp_pkg::CSR_SLAVE_ADDRESS, 16'hFF00);
      write_reg(msrp_pkg::CSR_TIMEOUT_MS, 16'h0000);
      @(posedge clock);
      queue_op(msrp_pkg::OP_START, 8'h00, 1'b0, 1'b0);
      queue_op(msrp_pkg::OP_TICK, 8'h00, 1'b0, 1'b0);
      queue_op(msrp_pkg::OP_START, 8'h00, 1'b0, 1'b0);
      make_reply(8'h00, 16'h8001, fr);
      queue_reply(fr, 1'b1, 0);
      queue_op(msrp_pkg::OP_TICK, 8'h00, 1'b1, 1'b0);
      queue_op(msrp_pkg::OP_START, 8'h00, 1'b0, 1'b0);
      make_reply(8'h00, 16'h1234, fr);
      fr[1] = 8'h04;
      queue_reply(fr, 1'b1, 0);
      settle_all();

      // highest address, one tick of grace, overlong reply
      write_reg(msrp_pkg::CSR_SLAVE_ADDRESS, 16'h00FF);
      write_reg(msrp_pkg::CSR_TIMEOUT_MS, 16'h0001);
      @(posedge clock);
      queue_op(msrp_pkg::OP_START, 8'h00, 1'b0, 1'b0);
      queue_op(msrp_pkg::OP_TICK, 8'h00, 1'b0, 1'b0);
      queue_op(msrp_pkg::OP_TICK, 8'h00, 1'b0, 1'b0);
      queue_op(msrp_pkg::OP_START, 8'h00, 1'b0, 1'b0);
      make_reply(8'hFF, 16'h7FFF, fr);
      repeat (11) fr.push_back(8'($urandom));
      queue_reply(fr, 1'b1, 0);
      settle_all();

      for (int phase = 0; phase < 4; phase++) begin
         write_reg(msrp_pkg::CSR_SLAVE_ADDRESS, 16'($urandom));
         case (phase)
            0: write_reg(msrp_pkg::CSR_TIMEOUT_MS, 16'($urandom_range(0, 3)));
            1: write_reg(msrp_pkg::CSR_TIMEOUT_MS, 16'($urandom_range(2, 6)));
            2: write_reg(msrp_pkg::CSR_TIMEOUT_MS, 16'($urandom_range(5, 12)));
            default: write_reg(msrp_pkg::CSR_TIMEOUT_MS, msrp_pkg::TIMEOUT_MS_RESET);
         endcase
         @(posedge clock);
         if (phase == 1) holds_asked++;
         while (outgoing_ops.size() < RANDOM_OPS_PER_SETTING) add_random_sequence();
         settle_all();
      end

      // longer timeout runs out on the final tick
      write_reg(msrp_pkg::CSR_TIMEOUT_MS, 16'd40);
      @(posedge clock);
      queue_op(msrp_pkg::OP_START, 8'h00, 1'b0, 1'b0);
      repeat (41) queue_op(msrp_pkg::OP_TICK, 8'($urandom), 1'($urandom), 1'b0);
      queue_op(msrp_pkg::OP_RX_BYTE, cfg_address, 1'b1, 1'b0);
      settle_all();

      mismatches += awaited_results.size();
      $display("%0d requests and %0d results over %0d register writes; %0d request bytes",
               ops_taken, results_taken, csr_writes, tx_bytes_seen);
      $display("replies: %0d ok, %0d format, %0d crc, %0d timeout; %0d mismatches",
               status_seen[msrp_pkg::STATUS_OK], status_seen[msrp_pkg::STATUS_FORMAT],
               status_seen[msrp_pkg::STATUS_CRC], status_seen[msrp_pkg::STATUS_TIMEOUT],
               mismatches);
      if (mismatches == 0) begin
         $display("[modbus_single_register_poller] OK");
      end else begin
         $display("[modbus_single_register_poller] ERROR");
      end
      $finish;
   end

endmodule
